// ----- hw/rtl/wfba_pkg.sv -----
`timescale 1ns / 1ps
// Package for the worst-fit block allocator.
// Command codes, register map, state type; no dependencies.
package wfba_pkg;

    localparam int CNT_W   = 5;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;
    localparam int IN_IDX_W  = 4;
    localparam int IN_SIZE_W = 16;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    localparam logic REG_BLOCK_COUNT = 1'b0;

    localparam logic [CNT_W-1:0] BLOCK_COUNT_RESET = 5'd16;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

endpackage

// ----- hw/rtl/wfba_cell.sv -----
`timescale 1ns / 1ps
// One cell of the allocator chain: holds one block's free size and
// refines the passing search packet. Depends on wfba_pkg.
module wfba_cell #(
    parameter int IDX_W      = 4,
    parameter int SIZE_WIDTH = 16,
    parameter int CELL_INDEX = 0
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [wfba_pkg::CNT_W-1:0]     count,
    input  logic [SIZE_WIDTH-1:0]          job,
    input  logic                           wr_en,
    input  logic [IDX_W-1:0]               wr_idx,
    input  logic [SIZE_WIDTH-1:0]          wr_data,
    input  logic                           in_valid,
    input  logic [SIZE_WIDTH-1:0]          in_best,
    input  logic [IDX_W-1:0]               in_idx,
    output logic                           out_valid,
    output logic [SIZE_WIDTH-1:0]          out_best,
    output logic [IDX_W-1:0]               out_idx
);
    import wfba_pkg::*;

    logic [SIZE_WIDTH-1:0] free_reg;
    logic                  valid_reg;
    logic [SIZE_WIDTH-1:0] best_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic                  active;
    logic                  take;

    assign active = (32'(CELL_INDEX) < 32'(count));
    assign take   = active && (free_reg >= job) && (free_reg > in_best);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en && (wr_idx == IDX_W'(CELL_INDEX)))
            begin
                free_reg <= wr_data;
            end
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= take ? free_reg : in_best;
        idx_reg  <= take ? IDX_W'(CELL_INDEX) : in_idx;
    end

    assign out_valid = valid_reg;
    assign out_best  = best_reg;
    assign out_idx   = idx_reg;

endmodule

// ----- hw/rtl/worst_fit_block_allocator.sv -----
`timescale 1ns / 1ps
// Worst-fit block allocator top level: request handshake, register port,
// cell chain and write-back. Depends on wfba_pkg and wfba_cell.
//
//  channel   | handshake              | payload
//  ----------+------------------------+------------------------------------
//  request   | start, busy            | command, load_index, size
//  result    | done (one-cycle pulse) | placed, chosen_block, free_before
//  register  | psel, penable, pwrite  | paddr, pwdata, prdata, pready
//
// A load writes the indexed free size and gives no result. An allocate holds
// busy while the search packet walks one cell a cycle down the chain; the
// result pulses in the cycle after the packet leaves the last cell.
// Reset clears every free size and sets block_count to 16; no clearing pass.
// Results cannot be stalled; a new request may be taken while done pulses.
module worst_fit_block_allocator #(
    parameter int MAX_BLOCKS = 16,
    parameter int SIZE_WIDTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               command,
    input  logic [wfba_pkg::IN_IDX_W-1:0]      load_index,
    input  logic [wfba_pkg::IN_SIZE_W-1:0]     size,
    output logic                               done,
    output logic                               placed,
    output logic [wfba_pkg::IN_IDX_W-1:0]      chosen_block,
    output logic [wfba_pkg::IN_SIZE_W-1:0]     free_before,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [wfba_pkg::ADDR_W-1:0]        paddr,
    input  logic [wfba_pkg::DATA_W-1:0]        pwdata,
    output logic [wfba_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);
    import wfba_pkg::*;

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      block_count_reg;
    logic [SIZE_WIDTH-1:0] job_reg;
    logic                  inj_reg;
    logic                  done_reg;
    logic                  placed_reg;
    logic [IN_IDX_W-1:0]   chosen_reg;
    logic [IN_SIZE_W-1:0]  free_before_reg;

    logic                  valid_chain [0:MAX_BLOCKS];
    logic [SIZE_WIDTH-1:0] best_chain  [0:MAX_BLOCKS];
    logic [IDX_W-1:0]      idx_chain   [0:MAX_BLOCKS];

    logic                  load_acc;
    logic                  alloc_acc;
    logic                  last_valid;
    logic [SIZE_WIDTH-1:0] last_best;
    logic [IDX_W-1:0]      last_idx;
    logic                  wb;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_idx;
    logic [SIZE_WIDTH-1:0] wr_data;
    logic                  cfg_wr;
    logic                  addr_hit;

    // register port
    assign pready   = 1'b1;
    assign addr_hit = (paddr[ADDR_W-1:2] == REG_BLOCK_COUNT);
    assign cfg_wr   = psel && penable && pwrite && pready && addr_hit;
    assign prdata   = addr_hit ? DATA_W'(block_count_reg) : '0;

    // request decode
    assign busy      = (state_reg == ST_SCAN);
    assign load_acc  = start && !busy && (command == CMD_LOAD);
    assign alloc_acc = start && !busy && (command == CMD_ALLOC);

    // chain
    assign valid_chain[0] = inj_reg;
    assign best_chain[0]  = '0;
    assign idx_chain[0]   = '0;

    assign last_valid = valid_chain[MAX_BLOCKS];
    assign last_best  = best_chain[MAX_BLOCKS];
    assign last_idx   = idx_chain[MAX_BLOCKS];

    assign wb      = last_valid && (last_best != '0);
    assign wr_en   = wb || (load_acc && (32'(load_index) < 32'(MAX_BLOCKS)));
    assign wr_idx  = wb ? last_idx : IDX_W'(load_index);
    assign wr_data = wb ? (last_best - job_reg) : SIZE_WIDTH'(size);

    genvar g;
    generate
        for (g = 0; g < MAX_BLOCKS; g++)
        begin : g_cell
            wfba_cell #(
                .IDX_W      (IDX_W),
                .SIZE_WIDTH (SIZE_WIDTH),
                .CELL_INDEX (g)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .count     (block_count_reg),
                .job       (job_reg),
                .wr_en     (wr_en),
                .wr_idx    (wr_idx),
                .wr_data   (wr_data),
                .in_valid  (valid_chain[g]),
                .in_best   (best_chain[g]),
                .in_idx    (idx_chain[g]),
                .out_valid (valid_chain[g+1]),
                .out_best  (best_chain[g+1]),
                .out_idx   (idx_chain[g+1])
            );
        end
    endgenerate

    // control
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (alloc_acc)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last_valid)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            block_count_reg <= BLOCK_COUNT_RESET;
            inj_reg         <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            inj_reg   <= alloc_acc;
            done_reg  <= last_valid;
            if (cfg_wr)
            begin
                block_count_reg <= pwdata[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (alloc_acc)
        begin
            job_reg <= SIZE_WIDTH'(size);
        end
        if (last_valid)
        begin
            placed_reg      <= (last_best != '0);
            chosen_reg      <= IN_IDX_W'(last_idx);
            free_before_reg <= IN_SIZE_W'(last_best);
        end
    end

    assign done         = done_reg;
    assign placed       = placed_reg;
    assign chosen_block = chosen_reg;
    assign free_before  = free_before_reg;

endmodule

// ----- hw/rtl/wfba_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the worst-fit block allocator, bound to the top.
// Depends on wfba_pkg.
module wfba_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           command,
    input logic                           done,
    input logic                           placed,
    input logic [wfba_pkg::IN_IDX_W-1:0]  chosen_block,
    input logic [wfba_pkg::IN_SIZE_W-1:0] free_before
);
    import wfba_pkg::*;

    // an allocate request holds the block busy
    a_alloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (command == CMD_ALLOC) |=> busy)
        else $error("allocate request did not raise busy");

    // a load never produces a result
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (command == CMD_LOAD) |=> !done)
        else $error("result after load request");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while still searching");

    a_wait_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !placed |-> (chosen_block == '0) && (free_before == '0))
        else $error("waiting result carries nonzero fields");

    a_placed_size: assert property (@(posedge clk) disable iff (!rst_n)
        done && placed |-> (free_before != '0))
        else $error("placed in an empty block");

endmodule

bind worst_fit_block_allocator wfba_checker u_wfba_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .done         (done),
    .placed       (placed),
    .chosen_block (chosen_block),
    .free_before  (free_before)
);
